/* src/ubfc_pkg.sv */
package ubfc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int LEVEL_W    = 7;
    localparam int KIND_W     = 3;
    localparam int BYTE_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RTS_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CTS_ENABLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CTS_GO_LEVEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RTS_STOP_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RTS_GO_LEVEL   = 3'd4;

    localparam logic [LEVEL_W-1:0] RTS_STOP_RESET = 7'd48;
    localparam logic [LEVEL_W-1:0] RTS_GO_RESET   = 7'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK     = 3'd0,
        KIND_HOST_WR  = 3'd1,
        KIND_HOST_RD  = 3'd2,
        KIND_LINE_RX  = 3'd3,
        KIND_TX_READY = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
    } t_dp_cmd;

endpackage

/* src/ubfc_ctrl.sv */
module ubfc_ctrl
    import ubfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_RESULT;
            end
            ST_RESULT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/ubfc_dpath.sv */
module ubfc_dpath
    import ubfc_pkg::*;
#(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_wdata,
    input  logic [KIND_W-1:0]             i_kind,
    input  logic [BYTE_W-1:0]             i_data,
    input  logic                          i_cts_level,
    output logic [BYTE_W-1:0]             o_read_data,
    output logic                          o_read_valid,
    output logic [BYTE_W-1:0]             o_send_data,
    output logic                          o_send_valid,
    output logic                          o_write_accepted,
    output logic                          o_rts_level,
    output logic                          o_txe_enabled,
    output logic [$clog2(RX_DEPTH+1)-1:0] o_rx_fill,
    output logic [$clog2(TX_DEPTH+1)-1:0] o_tx_fill,
    output logic                          o_rx_overflowed,
    output logic                          o_tx_overflowed,
    output logic                          o_tx_flow_stopped
);

    localparam int RCW = $clog2(RX_DEPTH + 1);
    localparam int TCW = $clog2(TX_DEPTH + 1);
    localparam int RPW = $clog2(RX_DEPTH);
    localparam int TPW = $clog2(TX_DEPTH);
    localparam int CMPW = (RCW > LEVEL_W) ? RCW : LEVEL_W;
    localparam logic [RCW-1:0] RX_FULL = RCW'(RX_DEPTH);
    localparam logic [TCW-1:0] TX_FULL = TCW'(TX_DEPTH);
    localparam logic [RPW-1:0] RX_LAST = RPW'(RX_DEPTH - 1);
    localparam logic [TPW-1:0] TX_LAST = TPW'(TX_DEPTH - 1);

    // configuration
    logic               r_rts_enable;
    logic               r_cts_enable;
    logic               r_cts_go_level;
    logic [LEVEL_W-1:0] r_rts_stop_level;
    logic [LEVEL_W-1:0] r_rts_go_level;

    // latched item
    t_kind              r_kind;
    logic [BYTE_W-1:0]  r_data;
    logic               r_cts;

    // buffer state
    logic [BYTE_W-1:0]  r_rx_mem [RX_DEPTH];
    logic [BYTE_W-1:0]  r_tx_mem [TX_DEPTH];
    logic [BYTE_W-1:0]  r_rx_q;
    logic [BYTE_W-1:0]  r_tx_q;
    logic [RPW-1:0]     r_rx_wr_pos, r_rx_rd_pos;
    logic [TPW-1:0]     r_tx_wr_pos, r_tx_rd_pos;
    logic [RCW-1:0]     r_rx_count;
    logic [TCW-1:0]     r_tx_count;
    logic               r_rx_over, r_tx_over, r_rts, r_tx_empty, r_tx_stop, r_txe;

    // result
    logic [BYTE_W-1:0]  r_read_data, r_send_data;
    logic               r_read_valid, r_send_valid, r_write_ok;

    logic [RCW-1:0]     rx_cnt_inc, rx_cnt_dec;
    logic [TCW-1:0]     tx_cnt_inc;
    logic               rx_push, rx_pop, tx_push, tx_pop;
    logic               cts_go;

    assign rx_cnt_inc = r_rx_count + RCW'(1);
    assign rx_cnt_dec = r_rx_count - RCW'(1);
    assign tx_cnt_inc = r_tx_count + TCW'(1);
    assign cts_go     = (r_cts == r_cts_go_level);

    assign rx_push = i_cmd.exec && (r_kind == KIND_LINE_RX) && (r_rx_count != RX_FULL);
    assign rx_pop  = i_cmd.exec && (r_kind == KIND_HOST_RD) && (r_rx_count != '0);
    assign tx_push = i_cmd.exec && (r_kind == KIND_HOST_WR) && (r_tx_count != TX_FULL);
    assign tx_pop  = i_cmd.exec && (r_kind == KIND_TX_READY) && r_txe
                     && (r_tx_count != '0) && !(r_cts_enable && !cts_go);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rts_enable     <= 1'b0;
            r_cts_enable     <= 1'b0;
            r_cts_go_level   <= 1'b0;
            r_rts_stop_level <= RTS_STOP_RESET;
            r_rts_go_level   <= RTS_GO_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RTS_ENABLE:     r_rts_enable     <= i_cfg_wdata[0];
                CFG_CTS_ENABLE:     r_cts_enable     <= i_cfg_wdata[0];
                CFG_CTS_GO_LEVEL:   r_cts_go_level   <= i_cfg_wdata[0];
                CFG_RTS_STOP_LEVEL: r_rts_stop_level <= i_cfg_wdata;
                CFG_RTS_GO_LEVEL:   r_rts_go_level   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= t_kind'(i_kind);
            r_data <= i_data;
            r_cts  <= i_cts_level;
        end
    end

    // read ports run every cycle, data at the head is ready before the step
    always_ff @(posedge i_clk) begin
        if (rx_push) begin
            r_rx_mem[r_rx_wr_pos] <= r_data;
        end
        r_rx_q <= r_rx_mem[r_rx_rd_pos];
    end

    always_ff @(posedge i_clk) begin
        if (tx_push) begin
            r_tx_mem[r_tx_wr_pos] <= r_data;
        end
        r_tx_q <= r_tx_mem[r_tx_rd_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr_pos  <= '0;
            r_rx_rd_pos  <= '0;
            r_rx_count   <= '0;
            r_rx_over    <= 1'b0;
            r_rts        <= 1'b0;
            r_tx_wr_pos  <= '0;
            r_tx_rd_pos  <= '0;
            r_tx_count   <= '0;
            r_tx_over    <= 1'b0;
            r_tx_empty   <= 1'b1;
            r_tx_stop    <= 1'b0;
            r_txe        <= 1'b0;
            r_read_valid <= 1'b0;
            r_send_valid <= 1'b0;
            r_write_ok   <= 1'b0;
            r_read_data  <= '0;
            r_send_data  <= '0;
        end else if (i_cmd.exec) begin
            r_read_valid <= rx_pop;
            r_read_data  <= rx_pop ? r_rx_q : '0;
            r_send_valid <= tx_pop;
            r_send_data  <= tx_pop ? r_tx_q : '0;
            r_write_ok   <= tx_push;
            case (r_kind)
                KIND_TICK: begin
                    if (r_tx_stop && cts_go) begin
                        r_txe     <= 1'b1;
                        r_tx_stop <= 1'b0;
                    end
                end
                KIND_HOST_WR: begin
                    if (tx_push) begin
                        r_tx_wr_pos <= (r_tx_wr_pos == TX_LAST) ? '0 : r_tx_wr_pos + TPW'(1);
                        r_tx_count  <= tx_cnt_inc;
                        r_txe       <= 1'b1;
                        if (tx_cnt_inc == TX_FULL) begin
                            r_tx_over <= 1'b1;
                        end
                    end else begin
                        r_tx_over <= 1'b1;
                    end
                    if (r_tx_empty) begin
                        r_txe <= 1'b1;
                    end
                end
                KIND_HOST_RD: begin
                    if (rx_pop) begin
                        r_rx_rd_pos <= (r_rx_rd_pos == RX_LAST) ? '0 : r_rx_rd_pos + RPW'(1);
                        r_rx_count  <= rx_cnt_dec;
                        if (r_rts_enable && (CMPW'(rx_cnt_dec) <= CMPW'(r_rts_go_level))) begin
                            r_rts <= 1'b0;
                        end
                    end
                end
                KIND_LINE_RX: begin
                    if (rx_push) begin
                        r_rx_wr_pos <= (r_rx_wr_pos == RX_LAST) ? '0 : r_rx_wr_pos + RPW'(1);
                        r_rx_count  <= rx_cnt_inc;
                        if (rx_cnt_inc == RX_FULL) begin
                            r_rx_over <= 1'b1;
                        end
                        if (r_rts_enable
                            && (CMPW'(rx_cnt_inc) >= CMPW'(r_rts_stop_level))) begin
                            r_rts <= 1'b1;
                        end
                    end else begin
                        r_rx_over <= 1'b1;
                        if (r_rts_enable
                            && (CMPW'(r_rx_count) >= CMPW'(r_rts_stop_level))) begin
                            r_rts <= 1'b1;
                        end
                    end
                end
                KIND_TX_READY: begin
                    // masked interrupt: nothing happens
                    if (r_txe) begin
                        if (r_tx_count != '0) begin
                            if (r_cts_enable && !cts_go) begin
                                r_txe     <= 1'b0;
                                r_tx_stop <= 1'b1;
                            end else begin
                                r_tx_empty  <= 1'b0;
                                r_tx_count  <= r_tx_count - TCW'(1);
                                r_tx_rd_pos <= (r_tx_rd_pos == TX_LAST) ? '0
                                               : r_tx_rd_pos + TPW'(1);
                            end
                        end else begin
                            r_tx_empty <= 1'b1;
                            r_txe      <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_read_data       = r_read_data;
    assign o_read_valid      = r_read_valid;
    assign o_send_data       = r_send_data;
    assign o_send_valid      = r_send_valid;
    assign o_write_accepted  = r_write_ok;
    assign o_rts_level       = r_rts;
    assign o_txe_enabled     = r_txe;
    assign o_rx_fill         = r_rx_count;
    assign o_tx_fill         = r_tx_count;
    assign o_rx_overflowed   = r_rx_over;
    assign o_tx_overflowed   = r_tx_over;
    assign o_tx_flow_stopped = r_tx_stop;

    a_rx_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_count <= RX_FULL) && (r_tx_count <= TX_FULL))
        else $error("buffer count beyond depth");

    a_tx_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tx_count == '0) |-> (r_tx_wr_pos == r_tx_rd_pos))
        else $error("tx pointers apart with empty buffer");

    a_state_only_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !i_cmd.exec) |=> ($stable(r_rx_count) && $stable(r_tx_count)
                                      && $stable(r_txe)))
        else $error("buffer state moved outside an item step");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_pop || tx_pop) |-> ((r_rx_count != '0) || (r_tx_count != '0)))
        else $error("pop from empty buffer");

endmodule

/* src/uart_buffered_flow_control.sv */
// UART buffering with RTS/CTS flow control: a host side and a line side share
// a 64-entry (RX_DEPTH) receive ring and a 64-entry (TX_DEPTH) transmit ring,
// each kept in a memory with a registered read port. Each item is one event
// (tick, host write, host read, line byte, transmitter ready); it is latched in
// ST_IDLE, applied to the buffers in ST_EXEC, and its result is presented in
// ST_RESULT until i_out_ready takes it. The block takes a new item only after
// the previous result has been taken. Status outputs (fills, overflow flags,
// RTS, interrupt enable, CTS stop) show the state after the item; read and
// send bytes are zero unless their valid is set. Configuration writes are
// registered and must be made while idle.
module uart_buffered_flow_control
    import ubfc_pkg::*;
#(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [KIND_W-1:0]             i_kind,
    input  logic [BYTE_W-1:0]             i_data,
    input  logic                          i_cts_level,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [BYTE_W-1:0]             o_read_data,
    output logic                          o_read_valid,
    output logic [BYTE_W-1:0]             o_send_data,
    output logic                          o_send_valid,
    output logic                          o_write_accepted,
    output logic                          o_rts_level,
    output logic                          o_txe_enabled,
    output logic [$clog2(RX_DEPTH+1)-1:0] o_rx_fill,
    output logic [$clog2(TX_DEPTH+1)-1:0] o_tx_fill,
    output logic                          o_rx_overflowed,
    output logic                          o_tx_overflowed,
    output logic                          o_tx_flow_stopped
);

    t_dp_cmd cmd;

    ubfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    ubfc_dpath #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_kind            (i_kind),
        .i_data            (i_data),
        .i_cts_level       (i_cts_level),
        .o_read_data       (o_read_data),
        .o_read_valid      (o_read_valid),
        .o_send_data       (o_send_data),
        .o_send_valid      (o_send_valid),
        .o_write_accepted  (o_write_accepted),
        .o_rts_level       (o_rts_level),
        .o_txe_enabled     (o_txe_enabled),
        .o_rx_fill         (o_rx_fill),
        .o_tx_fill         (o_tx_fill),
        .o_rx_overflowed   (o_rx_overflowed),
        .o_tx_overflowed   (o_tx_overflowed),
        .o_tx_flow_stopped (o_tx_flow_stopped)
    );

endmodule

/* tb/sv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ubfc_pkg::*;

    localparam int RX_SLOTS      = 64;
    localparam int TX_SLOTS      = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int MAX_PRINTS    = 40;

    // kinds with no function, the block only reports status for them
    localparam logic [KIND_W-1:0] KIND_RSVD5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

    typedef enum int {
        MIX_EVEN,
        MIX_FILL,
        MIX_DRAIN
    } t_mix;

    typedef struct packed {
        logic [BYTE_W-1:0]  rd_byte;
        logic               rd_ok;
        logic [BYTE_W-1:0]  tx_byte;
        logic               tx_ok;
        logic               wr_ok;
        logic               rts;
        logic               txe;
        logic [LEVEL_W-1:0] rx_fill;
        logic [LEVEL_W-1:0] tx_fill;
        logic               rx_ovf;
        logic               tx_ovf;
        logic               tx_held;
    } t_uart_status;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx     = CFG_RTS_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  in_valid    = 1'b0;
    logic [KIND_W-1:0]     ev_kind     = KIND_TICK;
    logic [BYTE_W-1:0]     ev_data     = '0;
    logic                  ev_cts      = 1'b0;
    logic                  out_ready   = 1'b0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [BYTE_W-1:0]     o_read_data;
    logic                  o_read_valid;
    logic [BYTE_W-1:0]     o_send_data;
    logic                  o_send_valid;
    logic                  o_write_accepted;
    logic                  o_rts_level;
    logic                  o_txe_enabled;
    logic [LEVEL_W-1:0]    o_rx_fill;
    logic [LEVEL_W-1:0]    o_tx_fill;
    logic                  o_rx_overflowed;
    logic                  o_tx_overflowed;
    logic                  o_tx_flow_stopped;

    t_uart_status pending_status[$];
    int           mismatches   = 0;
    bit           gaps_on      = 1'b0;
    bit           stalls_on    = 1'b0;
    int           hold_request = 0;

    // predictor configuration
    logic               m_rts_en   = 1'b0;
    logic               m_cts_en   = 1'b0;
    logic               m_cts_go   = 1'b0;
    logic [LEVEL_W-1:0] m_rts_stop = RTS_STOP_RESET;
    logic [LEVEL_W-1:0] m_rts_go   = RTS_GO_RESET;

    // predictor state
    logic [BYTE_W-1:0] rx_mem[RX_SLOTS];
    logic [BYTE_W-1:0] tx_mem[TX_SLOTS];
    int unsigned       rx_wr   = 0;
    int unsigned       rx_rd   = 0;
    int unsigned       rx_cnt  = 0;
    int unsigned       tx_wr   = 0;
    int unsigned       tx_rd   = 0;
    int unsigned       tx_cnt  = 0;
    logic              rx_ovf  = 1'b0;
    logic              rts_on  = 1'b0;
    logic              tx_ovf  = 1'b0;
    logic              tx_idle = 1'b1;
    logic              tx_held = 1'b0;
    logic              txe_on  = 1'b0;

    uart_buffered_flow_control DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (ev_kind),
        .i_data            (ev_data),
        .i_cts_level       (ev_cts),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_read_data       (o_read_data),
        .o_read_valid      (o_read_valid),
        .o_send_data       (o_send_data),
        .o_send_valid      (o_send_valid),
        .o_write_accepted  (o_write_accepted),
        .o_rts_level       (o_rts_level),
        .o_txe_enabled     (o_txe_enabled),
        .o_rx_fill         (o_rx_fill),
        .o_tx_fill         (o_tx_fill),
        .o_rx_overflowed   (o_rx_overflowed),
        .o_tx_overflowed   (o_tx_overflowed),
        .o_tx_flow_stopped (o_tx_flow_stopped)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_uart_status apply_uart_event(input logic [KIND_W-1:0] k,
                                                      input logic [BYTE_W-1:0] d,
                                                      input logic c);
        t_uart_status s;
        s = '0;
        case (k)
            KIND_TICK: begin
                if (tx_held && c == m_cts_go) begin
                    txe_on  = 1'b1;
                    tx_held = 1'b0;
                end
            end
            KIND_HOST_WR: begin
                if (tx_cnt < TX_SLOTS) begin
                    tx_mem[tx_wr] = d;
                    tx_wr   = (tx_wr + 1) % TX_SLOTS;
                    tx_cnt++;
                    txe_on  = 1'b1;
                    s.wr_ok = 1'b1;
                    // reaching full counts as overflow too
                    if (tx_cnt == TX_SLOTS) tx_ovf = 1'b1;
                end else begin
                    tx_ovf = 1'b1;
                end
                if (tx_idle) txe_on = 1'b1;
            end
            KIND_HOST_RD: begin
                if (rx_cnt != 0) begin
                    s.rd_byte = rx_mem[rx_rd];
                    s.rd_ok   = 1'b1;
                    rx_rd     = (rx_rd + 1) % RX_SLOTS;
                    rx_cnt--;
                    if (m_rts_en && rx_cnt <= m_rts_go) rts_on = 1'b0;
                end
            end
            KIND_LINE_RX: begin
                if (rx_cnt < RX_SLOTS) begin
                    rx_mem[rx_wr] = d;
                    rx_wr = (rx_wr + 1) % RX_SLOTS;
                    rx_cnt++;
                    if (rx_cnt == RX_SLOTS) rx_ovf = 1'b1;
                end else begin
                    rx_ovf = 1'b1;
                end
                if (m_rts_en && rx_cnt >= m_rts_stop) rts_on = 1'b1;
            end
            KIND_TX_READY: begin
                // masked interrupt: nothing happens
                if (txe_on) begin
                    if (tx_cnt > 0) begin
                        if (m_cts_en && c != m_cts_go) begin
                            txe_on  = 1'b0;
                            tx_held = 1'b1;
                        end else begin
                            tx_idle   = 1'b0;
                            tx_cnt--;
                            s.tx_byte = tx_mem[tx_rd];
                            s.tx_ok   = 1'b1;
                            tx_rd     = (tx_rd + 1) % TX_SLOTS;
                        end
                    end else begin
                        tx_idle = 1'b1;
                        txe_on  = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        s.rts     = rts_on;
        s.txe     = txe_on;
        s.rx_fill = LEVEL_W'(rx_cnt);
        s.tx_fill = LEVEL_W'(tx_cnt);
        s.rx_ovf  = rx_ovf;
        s.tx_ovf  = tx_ovf;
        s.tx_held = tx_held;
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] got,
                               input logic [BYTE_W-1:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic compare_status(input t_uart_status got, input t_uart_status want);
        check_field("read_data",       got.rd_byte, want.rd_byte);
        check_field("read_valid",      BYTE_W'(got.rd_ok),   BYTE_W'(want.rd_ok));
        check_field("send_data",       got.tx_byte, want.tx_byte);
        check_field("send_valid",      BYTE_W'(got.tx_ok),   BYTE_W'(want.tx_ok));
        check_field("write_accepted",  BYTE_W'(got.wr_ok),   BYTE_W'(want.wr_ok));
        check_field("rts_level",       BYTE_W'(got.rts),     BYTE_W'(want.rts));
        check_field("txe_enabled",     BYTE_W'(got.txe),     BYTE_W'(want.txe));
        check_field("rx_fill",         BYTE_W'(got.rx_fill), BYTE_W'(want.rx_fill));
        check_field("tx_fill",         BYTE_W'(got.tx_fill), BYTE_W'(want.tx_fill));
        check_field("rx_overflowed",   BYTE_W'(got.rx_ovf),  BYTE_W'(want.rx_ovf));
        check_field("tx_overflowed",   BYTE_W'(got.tx_ovf),  BYTE_W'(want.tx_ovf));
        check_field("tx_flow_stopped", BYTE_W'(got.tx_held), BYTE_W'(want.tx_held));
    endtask

    // check results first, then predict the item taken at this edge
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_status.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                compare_status({o_read_data, o_read_valid, o_send_data, o_send_valid,
                                o_write_accepted, o_rts_level, o_txe_enabled, o_rx_fill,
                                o_tx_fill, o_rx_overflowed, o_tx_overflowed,
                                o_tx_flow_stopped},
                               pending_status.pop_front());
            end
        end
        if (rst_n && in_valid && o_in_ready)
            pending_status.push_back(apply_uart_event(ev_kind, ev_data, ev_cts));
    end

    initial begin : result_sink
        int stall;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end else begin
                stall = stalls_on ? $urandom_range(0, 19) : 0;
            end
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!o_out_valid);
        end
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_event(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] d,
                              input logic c);
        int gap;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        ev_kind  = k;
        ev_data  = d;
        ev_cts   = c;
        in_valid = 1'b1;
        do @(posedge clk); while (!o_in_ready);
        @(negedge clk);
    endtask

    task automatic drain_to_idle();
        int waited;
        waited   = 0;
        in_valid = 1'b0;
        while (pending_status.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        if (pending_status.size() != 0) begin
            report_mismatch("results still missing");
            pending_status.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        @(negedge clk);
    endtask

    task automatic set_flow_config(input logic rts_en, input logic cts_en, input logic cts_go,
                                   input logic [LEVEL_W-1:0] stop_lvl,
                                   input logic [LEVEL_W-1:0] go_lvl);
        drain_to_idle();
        write_reg(CFG_RTS_ENABLE, CFG_DATA_W'(rts_en));
        write_reg(CFG_CTS_ENABLE, CFG_DATA_W'(cts_en));
        write_reg(CFG_CTS_GO_LEVEL, CFG_DATA_W'(cts_go));
        write_reg(CFG_RTS_STOP_LEVEL, stop_lvl);
        write_reg(CFG_RTS_GO_LEVEL, go_lvl);
        cfg_we     = 1'b0;
        m_rts_en   = rts_en;
        m_cts_en   = cts_en;
        m_cts_go   = cts_go;
        m_rts_stop = stop_lvl;
        m_rts_go   = go_lvl;
    endtask

    function automatic logic pick_cts();
        return ($urandom_range(0, 3) != 0) ? m_cts_go : ~m_cts_go;
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input t_mix mix);
        int unsigned roll;
        int unsigned w_wr, w_rx, w_rd, w_tx;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin w_wr = 40; w_rx = 40; w_rd = 6;  w_tx = 8;  end
            MIX_DRAIN: begin w_wr = 8;  w_rx = 8;  w_rd = 35; w_tx = 35; end
            default:   begin w_wr = 20; w_rx = 20; w_rd = 20; w_tx = 20; end
        endcase
        if (roll < w_wr) return KIND_HOST_WR;
        roll -= w_wr;
        if (roll < w_rx) return KIND_LINE_RX;
        roll -= w_rx;
        if (roll < w_rd) return KIND_HOST_RD;
        roll -= w_rd;
        if (roll < w_tx) return KIND_TX_READY;
        roll -= w_tx;
        // last few percent go to unused kinds
        if (roll < 100 - w_wr - w_rx - w_rd - w_tx - 3) return KIND_TICK;
        case ($urandom_range(0, 2))
            0:       return KIND_RSVD5;
            1:       return KIND_RSVD6;
            default: return KIND_RSVD7;
        endcase
    endfunction

    task automatic test_idle_events();
        send_event(KIND_TICK, 8'h00, 1'b0);
        send_event(KIND_TICK, 8'hFF, 1'b1);
        send_event(KIND_HOST_RD, 8'h00, 1'b0);
        send_event(KIND_TX_READY, 8'h00, 1'b1);
        send_event(KIND_RSVD5, 8'hFF, 1'b1);
        send_event(KIND_RSVD6, 8'h00, 1'b0);
        send_event(KIND_RSVD7, 8'hFF, 1'b1);
    endtask

    task automatic test_transfer_basics();
        send_event(KIND_HOST_WR, 8'h00, 1'b0);
        send_event(KIND_HOST_WR, 8'hFF, 1'b1);
        send_event(KIND_TX_READY, 8'h00, 1'b1);
        send_event(KIND_TX_READY, 8'h00, 1'b0);
        send_event(KIND_TX_READY, 8'h00, 1'b0);
        send_event(KIND_LINE_RX, 8'hFF, 1'b0);
        send_event(KIND_LINE_RX, 8'h00, 1'b1);
        send_event(KIND_HOST_RD, 8'h00, 1'b0);
        send_event(KIND_HOST_RD, 8'h00, 1'b0);
        send_event(KIND_HOST_RD, 8'h00, 1'b0);
    endtask

    task automatic test_cts_stop();
        set_flow_config(1'b0, 1'b1, 1'b1, RTS_STOP_RESET, RTS_GO_RESET);
        send_event(KIND_HOST_WR, 8'h5A, 1'b0);
        send_event(KIND_TX_READY, 8'h00, 1'b0);
        send_event(KIND_TICK, 8'h00, 1'b0);
        // a write re-enables the interrupt while flow is held
        send_event(KIND_HOST_WR, 8'hC3, 1'b0);
        send_event(KIND_TX_READY, 8'h00, 1'b1);
        send_event(KIND_TX_READY, 8'h00, 1'b0);
        // release by a tick with cts handling switched off
        set_flow_config(1'b0, 1'b0, 1'b1, RTS_STOP_RESET, RTS_GO_RESET);
        send_event(KIND_TICK, 8'h00, 1'b1);
        send_event(KIND_TX_READY, 8'h00, 1'b0);
        send_event(KIND_TX_READY, 8'h00, 1'b0);
    endtask

    task automatic test_fill_and_overflow();
        int n;
        set_flow_config(1'b1, 1'b1, 1'b1, 7'd64, 7'd0);
        for (n = 0; n < RX_SLOTS + 6; n++) send_event(KIND_LINE_RX, 8'($urandom), 1'b1);
        for (n = 0; n < TX_SLOTS + 6; n++) send_event(KIND_HOST_WR, 8'($urandom), 1'b1);
        // hold flow on a full buffer, then a rejected write while still marked empty
        send_event(KIND_TX_READY, 8'h00, 1'b0);
        send_event(KIND_HOST_WR, 8'($urandom), 1'b0);
        for (n = 0; n < RX_SLOTS + 4; n++) send_event(KIND_HOST_RD, 8'($urandom), 1'b1);
        for (n = 0; n < TX_SLOTS + 4; n++) send_event(KIND_TX_READY, 8'($urandom), 1'b1);
        send_event(KIND_TICK, 8'h00, 1'b1);
    endtask

    task automatic test_backpressure();
        int n;
        gaps_on      = 1'b0;
        stalls_on    = 1'b0;
        hold_request = 150;
        for (n = 0; n < 30; n++)
            send_event(pick_kind(MIX_EVEN), 8'($urandom), pick_cts());
    endtask

    task automatic test_random_traffic();
        int   phase;
        int   n;
        t_mix mix;
        mix = MIX_EVEN;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_flow_config(1'b1, 1'b1, 1'b0, 7'd0, 7'd0);
                1: set_flow_config(1'b1, 1'b0, 1'b1, 7'd64, 7'd64);
                2: set_flow_config(1'b0, 1'b1, 1'b0, 7'd32, 7'd8);
                3: set_flow_config(1'b1, 1'b1, 1'b1, RTS_STOP_RESET, RTS_GO_RESET);
                default: set_flow_config(1'($urandom), 1'($urandom), 1'($urandom),
                                         LEVEL_W'($urandom_range(0, 64)),
                                         LEVEL_W'($urandom_range(0, 64)));
            endcase
            for (n = 0; n < 62; n++) begin
                if (n % 25 == 0) begin
                    mix       = t_mix'($urandom_range(0, 2));
                    gaps_on   = ($urandom_range(0, 3) != 0);
                    stalls_on = ($urandom_range(0, 3) != 0);
                end
                send_event(pick_kind(mix), 8'($urandom), pick_cts());
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge clk);
        rst_n     = 1'b1;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_idle_events();
        test_transfer_basics();
        test_cts_stop();
        test_fill_and_overflow();
        test_backpressure();
        test_random_traffic();
        drain_to_idle();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
